FILE: hw/rtl/tpg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpg_pkg
// Shared constants and types of the twiddle power generator: field width,
// configuration register indexes and their reset values.
// ----------------------------------------------------------------------------
package tpg_pkg;

  // default width of modulus, root, length and of every result field
  localparam int unsigned ModBitsDefault = 15;

  // configuration register index
  localparam int unsigned CfgIdxWidth = 2;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_MODULUS = 2'd0,
    CFG_ROOT    = 2'd1,
    CFG_LENGTH  = 2'd2
  } cfg_idx_e;

  // register values after reset, truncated to the field width where used
  localparam int unsigned ModulusReset = 4591;
  localparam int unsigned RootReset    = 3;
  localparam int unsigned LengthReset  = 761;

endpackage : tpg_pkg
`default_nettype wire

FILE: hw/rtl/tpg_mulmod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpg_mulmod
// Bit-serial modular multiplier, interleaved shift-add with reduction:
// scans the multiplier b most significant bit first, one bit a cycle.
// An operand a at or above q is first brought below q by a serial remainder
// pass; b may take any value. Gives 0 when q is below two.
// ----------------------------------------------------------------------------
module tpg_mulmod #(
  parameter int unsigned Width = tpg_pkg::ModBitsDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [Width-1:0] a_i,
  input  wire logic [Width-1:0] b_i,
  input  wire logic [Width-1:0] q_i,
  output logic                  busy_o,
  output logic      [Width-1:0] result_o
);
  import tpg_pkg::*;

  localparam int unsigned CntWidth = $clog2(Width + 1);

  logic [Width-1:0]    a_q, b_q, q_q, acc_q;
  logic [Width-1:0]    acc_d;
  logic [CntWidth-1:0] cnt_q;
  logic                busy_q, reduce_q;
  logic                bit_set;
  logic [Width+1:0]    addend, sum, red1, red2, q_ext;

  // one step: double, add on a set bit, then up to two subtractions of q;
  // while a is being reduced its own bits are shifted in instead
  always_comb begin
    q_ext   = {2'b00, q_q};
    bit_set = reduce_q ? a_q[Width-1] : b_q[Width-1];
    addend  = reduce_q ? {{(Width+1){1'b0}}, 1'b1} : {2'b00, a_q};
    sum     = {1'b0, acc_q, 1'b0} + (bit_set ? addend : '0);
    red1    = (sum >= q_ext) ? sum - q_ext : sum;
    red2    = (red1 >= q_ext) ? red1 - q_ext : red1;
    acc_d   = red2[Width-1:0];
  end

  // operand capture and step sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      reduce_q <= 1'b0;
      cnt_q    <= '0;
      a_q      <= '0;
      b_q      <= '0;
      q_q      <= '0;
      acc_q    <= '0;
    end else if (start_i) begin
      busy_q   <= 1'b1;
      reduce_q <= (a_i >= q_i);
      cnt_q    <= CntWidth'(Width);
      a_q      <= a_i;
      b_q      <= b_i;
      q_q      <= q_i;
      acc_q    <= '0;
    end else if (busy_q && reduce_q) begin
      if (cnt_q == CntWidth'(1)) begin
        // a mod q ready, multiplication proper follows
        reduce_q <= 1'b0;
        a_q      <= acc_d;
        acc_q    <= '0;
        cnt_q    <= CntWidth'(Width);
      end else begin
        acc_q <= acc_d;
        a_q   <= {a_q[Width-2:0], 1'b0};
        cnt_q <= cnt_q - CntWidth'(1);
      end
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= {b_q[Width-2:0], 1'b0};
      cnt_q <= cnt_q - CntWidth'(1);
      if (cnt_q == CntWidth'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o   = busy_q;
  assign result_o = (q_q[Width-1:1] == '0) ? '0 : acc_q;

endmodule : tpg_mulmod
`default_nettype wire

FILE: hw/rtl/tpg_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpg_div
// Bit-serial restoring divider: one quotient bit a cycle, truncating.
// The caller screens out a zero divisor.
// ----------------------------------------------------------------------------
module tpg_div #(
  parameter int unsigned Width = tpg_pkg::ModBitsDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [Width-1:0] dividend_i,
  input  wire logic [Width-1:0] divisor_i,
  output logic                  busy_o,
  output logic      [Width-1:0] quotient_o
);
  import tpg_pkg::*;

  localparam int unsigned CntWidth = $clog2(Width + 1);

  logic [Width-1:0]    dq_q, rem_q, div_q;
  logic [Width-1:0]    rem_d;
  logic [Width:0]      rem_sh;
  logic                fits;
  logic [CntWidth-1:0] cnt_q;
  logic                busy_q;

  // shift in the next dividend bit and try a subtraction
  always_comb begin
    rem_sh = {rem_q, dq_q[Width-1]};
    fits   = rem_sh >= {1'b0, div_q};
    rem_d  = fits ? Width'(rem_sh - {1'b0, div_q}) : rem_sh[Width-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      dq_q   <= '0;
      rem_q  <= '0;
      div_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntWidth'(Width);
      dq_q   <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dq_q  <= {dq_q[Width-2:0], fits};
      cnt_q <= cnt_q - CntWidth'(1);
      if (cnt_q == CntWidth'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = dq_q;

endmodule : tpg_div
`default_nettype wire

FILE: hw/rtl/twiddle_power_generator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twiddle_power_generator_top
// NTT twiddle factor generator: emits index, omega^index and the power of
// the inverse of omega modulo q, one word per input word.
// ----------------------------------------------------------------------------
// Each input word yields one output word. A word that starts a sequence
// (restart set, first word after reset, or word after the one flagged last)
// first derives omega = root^((q-1)/n) mod q and its inverse omega^(q-2)
// mod q, using a bit-serial divider and two bit-serial modular multipliers
// for 2*MOD_BITS square-and-multiply steps after the division. The time of
// every other word is set by one pass of the two multipliers that advance
// the powers, one bit of the multiplier per cycle. A pass first reduces
// any operand at or above the modulus (modulus lowered mid-sequence, or
// below two), and a stalled output word adds its stall.
// The output register lets the next word in while an earlier result waits.
// Configuration writes belong between words: root and length feed the next
// omega derivation, the modulus applies to every product from then on, and
// last compares with the live length.
module twiddle_power_generator_top #(
  parameter int unsigned MOD_BITS = tpg_pkg::ModBitsDefault
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration write channel
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [tpg_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  wire logic [MOD_BITS-1:0]              cfg_data_i,
  // input channel
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic                             in_restart_i,
  // output channel
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic      [MOD_BITS-1:0]              out_index_o,
  output logic      [MOD_BITS-1:0]              out_power_o,
  output logic      [MOD_BITS-1:0]              out_inverse_power_o,
  output logic                                  out_last_o
);
  import tpg_pkg::*;

  localparam int unsigned StepWidth = $clog2(MOD_BITS);
  localparam logic [MOD_BITS-1:0] One = MOD_BITS'(1);
  localparam logic [MOD_BITS-1:0] Two = MOD_BITS'(2);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DIV      = 6'b000010,
    S_POW_GO   = 6'b000100,
    S_POW_WAIT = 6'b001000,
    S_EMIT     = 6'b010000,
    S_ADV      = 6'b100000
  } state_e;

  state_e state_q;

  logic [MOD_BITS-1:0]  modulus_q, root_q, length_q;
  logic [MOD_BITS-1:0]  omega_q, inv_omega_q, cur_pow_q, cur_inv_q, idx_q;
  logic [MOD_BITS-1:0]  base_q, acc_q, exp_q;
  logic [StepWidth-1:0] step_q;
  logic                 inv_phase_q, active_q;
  logic                 out_valid_q, out_last_q;
  logic [MOD_BITS-1:0]  out_index_q, out_power_q, out_inv_q;

  logic                 in_acc, recompute, out_free, emit_load, q_small, step_last;
  logic [MOD_BITS-1:0]  acc_next, last_index;

  // unit handshakes and operands
  logic                 mul_a_start, mul_b_start, div_start;
  logic                 mul_a_busy, mul_b_busy, div_busy;
  logic [MOD_BITS-1:0]  mul_a_a, mul_a_b, mul_b_a, mul_b_b;
  logic [MOD_BITS-1:0]  mul_a_res, mul_b_res, div_quot;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign recompute   = in_restart_i || !active_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign emit_load   = (state_q == S_EMIT) && out_free;
  assign q_small     = (modulus_q < Two);
  assign step_last   = (step_q == StepWidth'(MOD_BITS - 1));
  assign acc_next    = exp_q[0] ? mul_a_res : acc_q;
  assign last_index  = length_q - One;

  // operand selection for the serial units
  always_comb begin
    mul_a_start = 1'b0;
    mul_b_start = 1'b0;
    div_start   = 1'b0;
    mul_a_a     = One;
    mul_a_b     = root_q;
    mul_b_a     = base_q;
    mul_b_b     = base_q;
    case (state_q)
      S_IDLE: begin
        // root reduced mod q alongside the exponent division
        mul_a_start = in_acc && recompute;
        div_start   = in_acc && recompute;
      end
      S_POW_GO: begin
        mul_a_start = 1'b1;
        mul_b_start = 1'b1;
        mul_a_a     = base_q;
        mul_a_b     = acc_q;
      end
      S_EMIT: begin
        mul_a_start = emit_load;
        mul_b_start = emit_load;
        mul_a_a     = omega_q;
        mul_a_b     = cur_pow_q;
        mul_b_a     = inv_omega_q;
        mul_b_b     = cur_inv_q;
      end
      default: ;
    endcase
  end

  tpg_mulmod #(.Width(MOD_BITS)) u_mul_a (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_a_start),
    .a_i      (mul_a_a),
    .b_i      (mul_a_b),
    .q_i      (modulus_q),
    .busy_o   (mul_a_busy),
    .result_o (mul_a_res)
  );

  tpg_mulmod #(.Width(MOD_BITS)) u_mul_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_b_start),
    .a_i      (mul_b_a),
    .b_i      (mul_b_b),
    .q_i      (modulus_q),
    .busy_o   (mul_b_busy),
    .result_o (mul_b_res)
  );

  tpg_div #(.Width(MOD_BITS)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (modulus_q - One),
    .divisor_i  (length_q),
    .busy_o     (div_busy),
    .quotient_o (div_quot)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MOD_BITS'(ModulusReset);
      root_q    <= MOD_BITS'(RootReset);
      length_q  <= MOD_BITS'(LengthReset);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MODULUS: modulus_q <= cfg_data_i;
        CFG_ROOT:    root_q    <= cfg_data_i;
        CFG_LENGTH:  length_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer: omega derivation, emission, power advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      omega_q     <= '0;
      inv_omega_q <= '0;
      cur_pow_q   <= One;
      cur_inv_q   <= One;
      idx_q       <= '0;
      active_q    <= 1'b0;
      base_q      <= '0;
      acc_q       <= '0;
      exp_q       <= '0;
      step_q      <= '0;
      inv_phase_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= recompute ? S_DIV : S_EMIT;
          end
        end
        S_DIV: begin
          if (!div_busy && !mul_a_busy) begin
            exp_q       <= (length_q == '0 || q_small) ? '0 : div_quot;
            base_q      <= mul_a_res;
            acc_q       <= One;
            step_q      <= '0;
            inv_phase_q <= 1'b0;
            state_q     <= S_POW_GO;
          end
        end
        S_POW_GO: begin
          state_q <= S_POW_WAIT;
        end
        S_POW_WAIT: begin
          if (!mul_a_busy && !mul_b_busy) begin
            if (step_last) begin
              if (!inv_phase_q) begin
                // omega found, now raise it to q-2
                omega_q     <= q_small ? '0 : acc_next;
                base_q      <= q_small ? '0 : acc_next;
                acc_q       <= One;
                exp_q       <= modulus_q - Two;
                step_q      <= '0;
                inv_phase_q <= 1'b1;
                state_q     <= S_POW_GO;
              end else begin
                inv_omega_q <= q_small ? '0 : acc_next;
                cur_pow_q   <= One;
                cur_inv_q   <= One;
                idx_q       <= '0;
                state_q     <= S_EMIT;
              end
            end else begin
              acc_q   <= acc_next;
              base_q  <= mul_b_res;
              exp_q   <= {1'b0, exp_q[MOD_BITS-1:1]};
              step_q  <= step_q + StepWidth'(1);
              state_q <= S_POW_GO;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            active_q <= (idx_q != last_index);
            idx_q    <= idx_q + One;
            state_q  <= S_ADV;
          end
        end
        S_ADV: begin
          if (!mul_a_busy && !mul_b_busy) begin
            cur_pow_q <= mul_a_res;
            cur_inv_q <= mul_b_res;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_index_q <= '0;
      out_power_q <= '0;
      out_inv_q   <= '0;
    end else if (emit_load) begin
      out_valid_q <= 1'b1;
      out_last_q  <= (idx_q == last_index);
      out_index_q <= idx_q;
      out_power_q <= cur_pow_q;
      out_inv_q   <= cur_inv_q;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_last_o          = out_last_q;
  assign out_index_o         = out_index_q;
  assign out_power_o         = out_power_q;
  assign out_inverse_power_o = out_inv_q;

  // serial units are at rest whenever a new word may enter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (!mul_a_busy && !mul_b_busy && !div_busy))
    else $error("serial unit busy while idle");

  // an emitted word always launches the power advance on both multipliers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_load |=> (mul_a_busy && mul_b_busy && state_q == S_ADV))
    else $error("power advance not launched after emit");

  // a sequence ends only with a word flagged last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(active_q) |-> (out_valid_o && out_last_o))
    else $error("sequence ended without last word");

endmodule : twiddle_power_generator_top
`default_nettype wire
